>>> rtl/core/s2d_pkg.sv
// ============================================================================
// s2d_pkg
// Shared types and constants for the signed integer to decimal text block.
// ============================================================================
package s2d_pkg;

    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // head entry of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic neg;
    } t_q_head;

endpackage

>>> rtl/core/s2d_front.sv
// ============================================================================
// s2d_front
// Takes requests, splits them into sign and unsigned magnitude, and holds
// them in a two-entry queue for the back end.
// ============================================================================
module s2d_front
    import s2d_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_value,
    output t_q_head              o_head,
    output logic [WORD_BITS-1:0] o_mag,
    input  logic                 i_pop
);

    logic [1:0]           r_vld, n_vld;
    logic [1:0]           r_neg;
    logic [WORD_BITS-1:0] r_mag [2];
    logic                 r_wptr;
    logic                 r_rptr;
    logic                 push;
    logic                 pop;
    logic                 in_neg;
    logic [WORD_BITS-1:0] in_mag;

    // sign is the top bit; magnitude of the most negative value wraps to 2^(W-1)
    assign in_neg = i_value[WORD_BITS-1];
    assign in_mag = in_neg ? (~i_value + {{(WORD_BITS-1){1'b0}}, 1'b1}) : i_value;

    assign o_ready = !r_vld[r_wptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && r_vld[r_rptr];

    assign o_head.valid = r_vld[r_rptr];
    assign o_head.neg   = r_neg[r_rptr];
    assign o_mag        = r_mag[r_rptr];

    // push and pop never touch the same entry
    always_comb begin
        n_vld = r_vld;
        if (push) begin
            n_vld[r_wptr] = 1'b1;
        end
        if (pop) begin
            n_vld[r_rptr] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 2'b00;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_neg[r_wptr] <= in_neg;
            r_mag[r_wptr] <= in_mag;
        end
    end

endmodule

>>> rtl/core/s2d_back.sv
// ============================================================================
// s2d_back
// Converts a magnitude to BCD one bit per cycle (shift and add three), then
// sends the sign and significant digits, at most one character per cycle.
// ============================================================================
module s2d_back
    import s2d_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_head              i_head,
    input  logic [WORD_BITS-1:0] i_mag,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CHAR_W-1:0]    o_character,
    output logic                 o_last
);

    // decimal digits needed for any WORD_BITS-bit magnitude
    localparam int NUM_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(WORD_BITS);
    localparam int DCNT_W     = $clog2(NUM_DIGITS);

    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WORD_BITS - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_DIGITS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DCNT_W-1:0]    r_dcnt, n_dcnt;
    logic                 r_neg, n_neg;
    logic                 r_lead, n_lead;
    logic                 r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]    r_o_char, n_o_char;
    logic                 r_o_last, n_o_last;

    logic [BCD_W-1:0]     bcd_adj;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 slot_free;
    logic                 last_digit;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[d*DIGIT_W +: DIGIT_W] = (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                ? r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3
                : r_bcd[d*DIGIT_W +: DIGIT_W];
        end
    end

    assign top_digit  = r_bcd[BCD_W-1 -: DIGIT_W];
    assign slot_free  = !r_o_valid || i_ready;
    assign last_digit = (r_dcnt == DCNT_LAST);
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_dcnt    = r_dcnt;
        n_neg     = r_neg;
        n_lead    = r_lead;
        n_o_valid = r_o_valid && !i_ready;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_bin   = i_mag;
                    n_bcd   = '0;
                    n_neg   = i_head.neg;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[WORD_BITS-1]};
                n_bin = {r_bin[WORD_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_dcnt  = '0;
                    n_lead  = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_lead && top_digit == '0 && !last_digit && !r_neg) begin
                    // leading zero, drop it
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_dcnt = r_dcnt + 1'b1;
                end else if (slot_free) begin
                    n_o_valid = 1'b1;
                    if (r_neg) begin
                        n_o_char = ASCII_MINUS;
                        n_o_last = 1'b0;
                        n_neg    = 1'b0;
                    end else begin
                        n_o_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                        n_o_last = last_digit;
                        n_lead   = 1'b0;
                        n_bcd    = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        n_dcnt   = r_dcnt + 1'b1;
                        if (last_digit) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_cnt    <= n_cnt;
        r_dcnt   <= n_dcnt;
        r_neg    <= n_neg;
        r_lead   <= n_lead;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == ASCII_MINUS |-> !o_last)
        else $error("minus sign flagged as last character");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == ASCII_MINUS ||
                     (o_character >= ASCII_ZERO && o_character <= ASCII_ZERO + 6'd9)))
        else $error("character outside sign and digit codes");

    a_conv_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |=> (r_state == S_CONV || r_state == S_EMIT))
        else $error("conversion left to a wrong state");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_CONV && r_cnt == '0)
        else $error("pop did not start a conversion");

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// ============================================================================
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per result, most
// significant first, with a minus sign for negative values.
// ============================================================================
//
//   channel   direction   handshake           payload
//   request   in          i_valid / o_ready   i_value
//   result    out         o_valid / i_ready   o_character, o_last
//
// conversion: a one-bit-per-cycle shift-and-add-3 converter, then the sign
//   and each decimal place in turn, a leading zero dropped, the rest sent
// reset: i_rst_n synchronous active low, empties the queue and the output
// stalls: a two-entry queue takes requests during a conversion while not full;
//   a held output register stalls only the back end
//
module signed_int_to_decimal_ascii
    import s2d_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request side
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_value,
    // result side
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CHAR_W-1:0]    o_character,
    output logic                 o_last
);

    // queue head toward the back end
    t_q_head              q_head;
    logic [WORD_BITS-1:0] q_mag;
    logic                 q_pop;

    // front: sign split, magnitude, two-entry queue
    s2d_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_head  (q_head),
        .o_mag   (q_mag),
        .i_pop   (q_pop)
    );

    // back: binary to bcd, leading zero drop, character output register
    s2d_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_mag       (q_mag),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
